/* rtl/ttg_pkg.sv */
package ttg_pkg;

  localparam int FIELD_W        = 32;
  localparam int OUT_W          = 16;
  localparam int COORD_BITS_DEF = 32;
  localparam int OUT_FRAC_DEF   = 14;
  localparam int C_BITS         = 23;
  localparam int L_BITS         = 48;
  localparam int SQ_X_BITS      = 64;
  localparam int SQ_R_BITS      = 32;
  localparam int NORM_STEP      = 8;

endpackage

/* rtl/ttg_mul.sv */
module ttg_mul import ttg_pkg::*; #(
  parameter int OPW = 33
) (
  input  logic                      clk,
  input  logic signed [OPW-1:0]     a,
  input  logic signed [OPW-1:0]     b,
  output logic signed [2*OPW-1:0]   p
);

  logic signed [2*OPW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

/* rtl/ttg_isqrt.sv */
module ttg_isqrt import ttg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SQ_X_BITS-1:0] x,
  output logic                 done,
  output logic [SQ_R_BITS-1:0] root
);

  localparam int CW = $clog2(SQ_R_BITS);

  logic [SQ_X_BITS-1:0] x_r;
  logic [SQ_R_BITS+2:0] rem_r;
  logic [SQ_R_BITS-1:0] root_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [SQ_R_BITS+2:0] rem2;
  logic [SQ_R_BITS+2:0] trial;
  logic                 ge;

  assign rem2  = {rem_r[SQ_R_BITS:0], x_r[SQ_X_BITS-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = (rem2 >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(SQ_R_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= x_r << 2;
      rem_r  <= ge ? rem2 - trial : rem2;
      root_r <= {root_r[SQ_R_BITS-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* rtl/ttg_div.sv */
module ttg_div import ttg_pkg::*; #(
  parameter int QB = 16,
  parameter int NW = 46
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NW-1:0]        num,
  input  logic [SQ_R_BITS-1:0] den,
  output logic                 done,
  output logic [QB-1:0]        quo
);

  localparam int CW = $clog2(QB);
  localparam int DW = SQ_R_BITS;

  logic [DW:0]   rem_r;
  logic [DW:0]   den_r;
  logic [QB-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   t;
  logic          ge;

  assign t  = {rem_r[DW-1:0], q_r[QB-1]};
  assign ge = (t >= den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(QB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= (DW+1)'(num[NW-1:QB]);
      q_r   <= num[QB-1:0];
      den_r <= {1'b0, den};
    end else if (busy_r) begin
      rem_r <= ge ? t - den_r : t;
      q_r   <= {q_r[QB-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

/* rtl/triangle_tangent_generator.sv */
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | pos_x/y/z, tex_u/v, last_vertex
// out     | output    | out_valid / out_ready | tangent_x/y/z, degenerate, last
//
// Corners 0 and 1 are only stored. The third corner runs the shared
// multiplier for eight products, a normalizing shift, three squares on the
// same multiplier, a 32-step square root and three divisions of
// OUT_FRAC_BITS+2 steps; all-zero cross terms skip to a degenerate output.
// in_ready is low from the third corner until the third result is taken.
// Reset is synchronous, active low, and clears the corner count.
module triangle_tangent_generator import ttg_pkg::*; #(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FIELD_W-1:0] in_pos_x,
  input  logic [FIELD_W-1:0] in_pos_y,
  input  logic [FIELD_W-1:0] in_pos_z,
  input  logic [FIELD_W-1:0] in_tex_u,
  input  logic [FIELD_W-1:0] in_tex_v,
  input  logic               in_last_vertex,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OUT_W-1:0]   out_tangent_x,
  output logic [OUT_W-1:0]   out_tangent_y,
  output logic [OUT_W-1:0]   out_tangent_z,
  output logic               out_degenerate,
  output logic               out_last
);

  localparam int W    = COORD_BITS;
  localparam int OPW  = (W + 1 > C_BITS + 1) ? W + 1 : C_BITS + 1;
  localparam int PW   = 2 * OPW;
  localparam int ACCW = PW + 1;
  localparam int QB   = OUT_FRAC_BITS + 2;
  localparam int SH   = OUT_FRAC_BITS + 8;
  localparam int NW   = C_BITS + SH + 1;
  localparam int EW   = QB + OUT_W;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_PROD = 10'b0000000010,
    S_ABS  = 10'b0000000100,
    S_NORM = 10'b0000001000,
    S_SQ   = 10'b0000010000,
    S_RTGO = 10'b0000100000,
    S_RTW  = 10'b0001000000,
    S_DVGO = 10'b0010000000,
    S_DVW  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]              corner_r;
  logic [2:0]              idx_r;
  logic [1:0]              ph_r;
  logic [1:0]              kdiv_r;
  logic [1:0]              ocnt_r;
  logic signed [W-1:0]     hp_r [6];
  logic signed [W-1:0]     ht_r [4];
  logic signed [W-1:0]     cp_r [3];
  logic signed [W-1:0]     cu_r;
  logic signed [W-1:0]     cv_r;
  logic signed [OPW-1:0]   opa_r;
  logic signed [OPW-1:0]   opb_r;
  logic signed [ACCW-1:0]  acc_r;
  logic [ACCW-1:0]         mag_r [3];
  logic                    neg_r [3];
  logic                    det_neg_r;
  logic                    degen_r;
  logic [SQ_R_BITS-1:0]    root_r;
  logic [OUT_W-1:0]        res_r [3];

  logic                    acc_in;
  logic signed [W-1:0]     ma, sa, mb, sb;
  logic [C_BITS-1:0]       c0, c1, c2, csq, cdv;
  logic signed [OPW-1:0]   opa_d, opb_d;
  logic signed [PW-1:0]    prod;
  logic signed [ACCW-1:0]  pe, sp, diff;
  logic                    flip;
  logic [ACCW-1:0]         or_w;
  logic                    sq_done, dv_done;
  logic [SQ_R_BITS-1:0]    sq_root;
  logic [QB-1:0]           quo, qs;
  logic [NW-1:0]           num;
  logic [EW-1:0]           qe, rv;

  assign acc_in   = in_valid & in_ready;
  assign in_ready = (state_r == S_IDLE);

  assign c0 = mag_r[0][ACCW-1 -: C_BITS];
  assign c1 = mag_r[1][ACCW-1 -: C_BITS];
  assign c2 = mag_r[2][ACCW-1 -: C_BITS];

  always_comb begin
    ma = cu_r; sa = ht_r[0]; mb = ht_r[3]; sb = ht_r[1];
    unique case (idx_r)
      3'd0: begin ma = cu_r;     sa = ht_r[0]; mb = ht_r[3]; sb = ht_r[1]; end
      3'd1: begin ma = cv_r;     sa = ht_r[1]; mb = ht_r[2]; sb = ht_r[0]; end
      3'd2: begin ma = cp_r[0];  sa = hp_r[0]; mb = ht_r[3]; sb = ht_r[1]; end
      3'd3: begin ma = hp_r[3];  sa = hp_r[0]; mb = cv_r;    sb = ht_r[1]; end
      3'd4: begin ma = cp_r[1];  sa = hp_r[1]; mb = ht_r[3]; sb = ht_r[1]; end
      3'd5: begin ma = hp_r[4];  sa = hp_r[1]; mb = cv_r;    sb = ht_r[1]; end
      3'd6: begin ma = cp_r[2];  sa = hp_r[2]; mb = ht_r[3]; sb = ht_r[1]; end
      3'd7: begin ma = hp_r[5];  sa = hp_r[2]; mb = cv_r;    sb = ht_r[1]; end
      default: ;
    endcase
  end

  always_comb begin
    unique case (idx_r[1:0])
      2'd0:    csq = c0;
      2'd1:    csq = c1;
      default: csq = c2;
    endcase
    unique case (kdiv_r)
      2'd0:    cdv = c0;
      2'd1:    cdv = c1;
      default: cdv = c2;
    endcase
  end

  always_comb begin
    if (state_r == S_SQ) begin
      opa_d = OPW'(csq);
      opb_d = OPW'(csq);
    end else begin
      opa_d = OPW'(ma) - OPW'(sa);
      opb_d = OPW'(mb) - OPW'(sb);
    end
  end

  ttg_mul #(.OPW(OPW)) u_mul (
    .clk (clk),
    .a   (opa_r),
    .b   (opb_r),
    .p   (prod)
  );

  assign pe   = ACCW'(prod);
  assign flip = det_neg_r & (idx_r[2] | idx_r[1]);
  assign sp   = flip ? -pe : pe;
  assign diff = acc_r - sp;
  assign or_w = mag_r[0] | mag_r[1] | mag_r[2];

  ttg_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_RTGO),
    .x     ({acc_r[L_BITS-1:0], (SQ_X_BITS-L_BITS)'(0)}),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign num = (NW'(cdv) << SH) + NW'(root_r >> 1);

  ttg_div #(.QB(QB), .NW(NW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DVGO),
    .num   (num),
    .den   (root_r),
    .done  (dv_done),
    .quo   (quo)
  );

  always_comb begin
    qs = (quo > (QB'(1) << OUT_FRAC_BITS)) ? (QB'(1) << OUT_FRAC_BITS) : quo;
    qe = EW'(qs);
    rv = neg_r[kdiv_r] ? -qe : qe;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (acc_in && corner_r[1]) state_nxt = S_PROD;
      S_PROD: if (ph_r == 2'd2 && idx_r == 3'd7) state_nxt = S_ABS;
      S_ABS:  state_nxt = S_NORM;
      S_NORM: begin
        if (or_w == '0) state_nxt = S_OUT;
        else if (or_w[ACCW-1]) state_nxt = S_SQ;
      end
      S_SQ:   if (ph_r == 2'd2 && idx_r == 3'd2) state_nxt = S_RTGO;
      S_RTGO: state_nxt = S_RTW;
      S_RTW:  if (sq_done) state_nxt = S_DVGO;
      S_DVGO: state_nxt = S_DVW;
      S_DVW:  if (dv_done) state_nxt = (kdiv_r == 2'd2) ? S_OUT : S_DVGO;
      S_OUT:  if (out_ready && ocnt_r == 2'd2) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      corner_r <= '0;
      idx_r    <= '0;
      ph_r     <= '0;
      kdiv_r   <= '0;
      ocnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (acc_in) begin
        if (corner_r[1]) corner_r <= '0;
        else corner_r <= in_last_vertex ? 2'd0 : corner_r + 2'd1;
        idx_r <= '0;
        ph_r  <= '0;
      end
      if (state_r == S_PROD || state_r == S_SQ) begin
        if (ph_r == 2'd2) begin
          ph_r  <= '0;
          idx_r <= (state_nxt == state_r) ? idx_r + 3'd1 : 3'd0;
        end else begin
          ph_r <= ph_r + 2'd1;
        end
      end
      if (state_r == S_RTW) kdiv_r <= '0;
      if (state_r == S_DVW && dv_done) kdiv_r <= kdiv_r + 2'd1;
      if (state_r == S_NORM) ocnt_r <= '0;
      if (state_r == S_DVW) ocnt_r <= '0;
      if (state_r == S_OUT && out_ready) ocnt_r <= ocnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      unique case (corner_r)
        2'd0: begin
          hp_r[0] <= in_pos_x[W-1:0];
          hp_r[1] <= in_pos_y[W-1:0];
          hp_r[2] <= in_pos_z[W-1:0];
          ht_r[0] <= in_tex_u[W-1:0];
          ht_r[1] <= in_tex_v[W-1:0];
        end
        2'd1: begin
          hp_r[3] <= in_pos_x[W-1:0];
          hp_r[4] <= in_pos_y[W-1:0];
          hp_r[5] <= in_pos_z[W-1:0];
          ht_r[2] <= in_tex_u[W-1:0];
          ht_r[3] <= in_tex_v[W-1:0];
        end
        default: begin
          cp_r[0] <= in_pos_x[W-1:0];
          cp_r[1] <= in_pos_y[W-1:0];
          cp_r[2] <= in_pos_z[W-1:0];
          cu_r    <= in_tex_u[W-1:0];
          cv_r    <= in_tex_v[W-1:0];
          degen_r <= 1'b0;
        end
      endcase
    end
    if ((state_r == S_PROD || state_r == S_SQ) && ph_r == 2'd0) begin
      opa_r <= opa_d;
      opb_r <= opb_d;
    end
    if (state_r == S_PROD && ph_r == 2'd2) begin
      if (!idx_r[0]) acc_r <= sp;
      if (idx_r == 3'd1) det_neg_r <= diff[ACCW-1];
      if (idx_r == 3'd3) mag_r[0] <= diff;
      if (idx_r == 3'd5) mag_r[1] <= diff;
      if (idx_r == 3'd7) mag_r[2] <= diff;
    end
    if (state_r == S_SQ && ph_r == 2'd2) begin
      acc_r <= (idx_r == 3'd0) ? pe : acc_r + pe;
    end
    if (state_r == S_ABS) begin
      for (int k = 0; k < 3; k++) begin
        neg_r[k] <= mag_r[k][ACCW-1];
        mag_r[k] <= mag_r[k][ACCW-1] ? -mag_r[k] : mag_r[k];
      end
    end
    if (state_r == S_NORM) begin
      if (or_w == '0) begin
        degen_r <= 1'b1;
        for (int k = 0; k < 3; k++) res_r[k] <= '0;
      end else if (!or_w[ACCW-1]) begin
        for (int k = 0; k < 3; k++) begin
          if (or_w[ACCW-1 -: NORM_STEP] == '0) mag_r[k] <= mag_r[k] << NORM_STEP;
          else mag_r[k] <= mag_r[k] << 1;
        end
      end
    end
    if (state_r == S_RTW && sq_done) root_r <= sq_root;
    if (state_r == S_DVW && dv_done) begin
      unique case (kdiv_r)
        2'd0:    res_r[0] <= rv[OUT_W-1:0];
        2'd1:    res_r[1] <= rv[OUT_W-1:0];
        default: res_r[2] <= rv[OUT_W-1:0];
      endcase
    end
  end

  assign out_valid      = (state_r == S_OUT);
  assign out_tangent_x  = res_r[0];
  assign out_tangent_y  = res_r[1];
  assign out_tangent_z  = res_r[2];
  assign out_degenerate = degen_r;
  assign out_last       = (ocnt_r == 2'd2);

endmodule

/* rtl/ttg_checker.sv */
module ttg_checker import ttg_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [OUT_W-1:0]   out_tangent_x,
  input logic [OUT_W-1:0]   out_tangent_y,
  input logic [OUT_W-1:0]   out_tangent_z,
  input logic               out_degenerate,
  input logic               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tangent_x) &&
      $stable(out_tangent_y) && $stable(out_tangent_z) && $stable(out_last))
    else $error("result request dropped or changed while stalled");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_tangent_x == '0 && out_tangent_y == '0 &&
      out_tangent_z == '0)
    else $error("degenerate result with nonzero tangent");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while results pending");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("result run broken before last copy");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("block not idle after last copy");

endmodule

bind triangle_tangent_generator ttg_checker u_ttg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_tangent_x  (out_tangent_x),
  .out_tangent_y  (out_tangent_y),
  .out_tangent_z  (out_tangent_z),
  .out_degenerate (out_degenerate),
  .out_last       (out_last)
);
